// ===== hdl/pfr_pkg.sv =====
// shared types, constants and crc helper for the packet frame receiver
package pfr_pkg;

  localparam int HEADER_BYTES_DEFAULT  = 5;
  localparam int PAYLOAD_BYTES_DEFAULT = 64;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0]  START_BYTE_RESET = 8'hAA;
  localparam logic [63:0] KEY_LOW_RESET    = 64'h0807060504030201;
  localparam logic [63:0] KEY_HIGH_RESET   = 64'h1615141312111009;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH   = 2'd2;

  localparam logic [1:0] ROLE_IGNORED = 2'd0;
  localparam logic [1:0] ROLE_HEADER  = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
  localparam logic [1:0] ROLE_CRC     = 2'd3;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [63:0] key_high;
    logic [63:0] key_low;
  } cfg_t;

  typedef struct packed {
    logic       frame_ok;
    logic       frame_done;
    logic [7:0] byte_index;
    logic [1:0] byte_role;
    logic [7:0] out_byte;
  } result_t;

  // crc-16/ccitt-false, one byte msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    begin
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        if (c[15]) begin
          c = {c[14:0], 1'b0} ^ CRC_POLY;
        end else begin
          c = {c[14:0], 1'b0};
        end
      end
      return c;
    end
  endfunction

endpackage

// ===== hdl/packet_frame_receiver.sv =====
// top level of the packet frame receiver
//
// received link bytes come in on the s_ stream, one request per byte; each
// byte gives exactly one result request on the m_ stream, in order
// a byte equal to the start byte opens a frame of header, payload and a
// two-byte crc (low byte first); payload bytes are rotated right by 3 and
// xored with the key, and a crc-16/ccitt-false runs over header and plain
// payload; the last crc byte raises tlast and reports the check in tdata
// the cfg channel writes start byte (0), key low (1) and key high (2) and
// is always ready; the user must make writes only while the stream is idle,
// and the block does not enforce it; result valid is registered and rises
// in the cycle after the input request is taken; one byte is taken every
// cycle unless stalled at the single output register after the framer;
// s_tready drops and the result holds only while it is full and not taken
// rst is synchronous; it empties the output register, restores the reset
// register values and returns the framer to waiting for a start byte
module packet_frame_receiver #(
  parameter int HEADER_BYTES  = pfr_pkg::HEADER_BYTES_DEFAULT,
  parameter int PAYLOAD_BYTES = pfr_pkg::PAYLOAD_BYTES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // rx_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // out_byte, byte_index, frame_ok, zeros
  output logic [1:0]                      m_tuser,   // byte_role
  output logic                            m_tlast,   // frame_done
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);

  pfr_pkg::cfg_t    cfg;
  pfr_pkg::result_t result;
  pfr_pkg::result_t out_reg;
  logic             fire;

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;

  pfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pfr_framer #(
    .HEADER_BYTES  (HEADER_BYTES),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_framer (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (s_tdata),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {7'd0, out_reg.frame_ok, out_reg.byte_index, out_reg.out_byte};
  assign m_tuser = out_reg.byte_role;
  assign m_tlast = out_reg.frame_done;

endmodule

// ===== hdl/pfr_cfg.sv =====
// configuration registers: start byte and the two key words
module pfr_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [63:0]                        cfg_data,
  output pfr_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= pfr_pkg::START_BYTE_RESET;
      cfg.key_low    <= pfr_pkg::KEY_LOW_RESET;
      cfg.key_high   <= pfr_pkg::KEY_HIGH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pfr_pkg::REG_START_BYTE: cfg.start_byte <= cfg_data[7:0];
        pfr_pkg::REG_KEY_LOW:    cfg.key_low    <= cfg_data;
        pfr_pkg::REG_KEY_HIGH:   cfg.key_high   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/pfr_framer.sv =====
// frame tracking, payload decipher and running crc for one byte per cycle in which fire is high
module pfr_framer #(
  parameter int HEADER_BYTES  = pfr_pkg::HEADER_BYTES_DEFAULT,
  parameter int PAYLOAD_BYTES = pfr_pkg::PAYLOAD_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       rx_byte,
  input  pfr_pkg::cfg_t    cfg,
  output pfr_pkg::result_t result
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_CRC     = 2'd3;

  localparam logic [7:0] HDR_COUNT  = 8'(HEADER_BYTES);
  localparam logic [7:0] DATA_COUNT = 8'(HEADER_BYTES + PAYLOAD_BYTES);
  localparam logic [1:0] PH_AFTER_START = (HEADER_BYTES <= 1) ? PH_PAYLOAD : PH_HEADER;

  logic [1:0]  phase, phase_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [15:0] crc_running, crc_running_next;
  logic [7:0]  crc_low, crc_low_next;

  logic [7:0]   count_inc;
  logic [7:0]   pay_pos;
  logic [127:0] key_all;
  logic [7:0]   key_sel;
  logic [7:0]   plain;

  assign count_inc = byte_count + 8'd1;
  assign pay_pos   = byte_count - HDR_COUNT;
  assign key_all   = {cfg.key_high, cfg.key_low};
  assign key_sel   = key_all[{pay_pos[3:0], 3'b000} +: 8];
  assign plain     = {rx_byte[2:0], rx_byte[7:3]} ^ key_sel;

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    crc_running_next = crc_running;
    crc_low_next     = crc_low;
    result.out_byte   = rx_byte;
    result.byte_role  = pfr_pkg::ROLE_IGNORED;
    result.byte_index = 8'd0;
    result.frame_done = 1'b0;
    result.frame_ok   = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (rx_byte == cfg.start_byte) begin
          crc_running_next = pfr_pkg::crc_feed(pfr_pkg::CRC_INIT, rx_byte);
          byte_count_next  = 8'd1;
          phase_next       = PH_AFTER_START;
          result.byte_role = pfr_pkg::ROLE_HEADER;
        end
      end
      PH_HEADER: begin
        result.byte_index = byte_count;
        result.byte_role  = pfr_pkg::ROLE_HEADER;
        crc_running_next  = pfr_pkg::crc_feed(crc_running, rx_byte);
        byte_count_next   = count_inc;
        if (count_inc >= HDR_COUNT) begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        result.out_byte   = plain;
        result.byte_index = byte_count;
        result.byte_role  = pfr_pkg::ROLE_PAYLOAD;
        crc_running_next  = pfr_pkg::crc_feed(crc_running, plain);
        byte_count_next   = count_inc;
        if (count_inc >= DATA_COUNT) begin
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        result.byte_index = byte_count;
        result.byte_role  = pfr_pkg::ROLE_CRC;
        if (byte_count == DATA_COUNT) begin
          crc_low_next    = rx_byte;
          byte_count_next = count_inc;
        end else begin
          result.frame_ok   = ({rx_byte, crc_low} == crc_running);
          result.frame_done = 1'b1;
          phase_next        = PH_IDLE;
          byte_count_next   = 8'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      byte_count  <= 8'd0;
      crc_running <= pfr_pkg::CRC_INIT;
      crc_low     <= 8'd0;
    end else if (fire) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      crc_running <= crc_running_next;
      crc_low     <= crc_low_next;
    end
  end

endmodule
